/* rtl/assert_macros.svh */
// Assertion macros used by the RTL. Defining NO_ASSERTIONS removes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising clock edge outside reset.
`define MCC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checked on every rising clock edge, reset included.
`define MCC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`else

`define MCC_ASSERT(lbl, clk, rst, prop)
`define MCC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* rtl/mcc_pkg.sv */
package mcc_pkg;

   localparam int CONTEXT_MAX_DEF = 16;
   localparam int PATTERN_MAX_DEF = 8;

   localparam int SYMBOL_W  = 8;
   localparam int POS_W     = 5;
   localparam int STATUS_W  = 2;
   localparam int PLEN_W    = 4;
   localparam int CLEN_W    = 5;
   localparam int PBYTES_W  = 64;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [STATUS_W-1:0] {
      ST_NONE     = 2'd0,
      ST_AGREE    = 2'd1,
      ST_CONFLICT = 2'd2
   } slot_status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PATTERN_BYTES  = 2'd0,
      REG_PATTERN_LENGTH = 2'd1,
      REG_CONTEXT_LENGTH = 2'd2
   } csr_reg_type;

   typedef struct packed {
      slot_status_type       status;
      logic [SYMBOL_W-1:0]   symbol;
   } slot_type;

   // Per-beat control that every slot cell sees.
   typedef struct packed {
      logic step;
      logic hit;
      logic clear;
   } strm_ctl_type;

endpackage

/* rtl/mcc_if.sv */
interface mcc_req_if import mcc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SYMBOL_W-1:0] symbol;
   logic                final_req;

   modport source (output valid, output symbol, output final_req, input ready);
   modport sink   (input valid, input symbol, input final_req, output ready);
endinterface

interface mcc_rsp_if import mcc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [POS_W-1:0]    position;
   logic [SYMBOL_W-1:0] consensus_symbol;
   logic [STATUS_W-1:0] status;
   logic                is_last;

   modport source (output valid, output position, output consensus_symbol,
                   output status, output is_last, input ready);
   modport sink   (input valid, input position, input consensus_symbol,
                   input status, input is_last, output ready);
endinterface

interface mcc_csr_if import mcc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [PBYTES_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/match_context_consensus.sv */
// Context consensus around every occurrence of a pattern in a byte stream.
// csr_chan (always ready) writes the pattern bytes, pattern length and context
// length (index 0, 1, 2), only while the block idles: a user rule, not enforced.
// req_chan carries one byte a beat, with final_req on the last byte of a stream.
// Bytes are taken one per cycle unless a final byte waits: the window shifts and
// every slot cell updates its consensus in the cycle the beat is accepted.
// A beat with final_req loads a snapshot of the 2*L slots into the report
// chain and clears the stream. rsp_chan then gives one beat per cycle while
// rsp_ready holds, slot 0 first, the first in the cycle after the final byte;
// is_last marks the final slot of the 2*L beats.
// Ordinary bytes keep flowing while a report drains. A byte with final_req
// waits while the previous report still has more than one beat to give, or
// while its last beat is held by a stalled receiver, so back-to-back streams
// are limited by the report length.
// When the receiver stalls, the head beat holds and the report waits.
// Reset restores the register defaults and empties the stream and the report
// chain; no clearing pass follows.
module match_context_consensus import mcc_pkg::*; #(
   parameter int CONTEXT_MAX = CONTEXT_MAX_DEF,
   parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mcc_csr_if.sink    csr_chan,
   mcc_req_if.sink    req_chan,
   mcc_rsp_if.source  rsp_chan
);

   localparam int WIN_DEPTH  = 2 * CONTEXT_MAX + PATTERN_MAX;
   localparam int SLOT_DEPTH = 2 * CONTEXT_MAX;

   logic [PBYTES_W-1:0]                pattern_bytes_ff;
   logic [PLEN_W-1:0]                  pattern_length_ff;
   logic [CLEN_W-1:0]                  context_length_ff;
   logic [PLEN_W-1:0]                  p_eff;
   logic [CLEN_W-1:0]                  l_eff;
   logic [WIN_DEPTH-1:0][SYMBOL_W-1:0] win_next;
   logic                               hit;
   logic                               rpt_free;
   strm_ctl_type                       ctl;
   slot_type [SLOT_DEPTH-1:0]          slot_merged;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff  <= '0;
         pattern_length_ff <= PLEN_W'(1);
         context_length_ff <= CLEN_W'(1);
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_PATTERN_BYTES:  pattern_bytes_ff  <= csr_chan.data;
            REG_PATTERN_LENGTH: pattern_length_ff <= csr_chan.data[PLEN_W-1:0];
            REG_CONTEXT_LENGTH: context_length_ff <= csr_chan.data[CLEN_W-1:0];
            default: begin
               pattern_bytes_ff <= pattern_bytes_ff;
            end
         endcase
      end
   end

   // Out-of-range lengths are clamped to the supported range.
   always_comb begin
      if (pattern_length_ff == '0) begin
         p_eff = PLEN_W'(1);
      end else if (int'(pattern_length_ff) > PATTERN_MAX) begin
         p_eff = PLEN_W'(PATTERN_MAX);
      end else begin
         p_eff = pattern_length_ff;
      end
      if (context_length_ff == '0) begin
         l_eff = CLEN_W'(1);
      end else if (int'(context_length_ff) > CONTEXT_MAX) begin
         l_eff = CLEN_W'(CONTEXT_MAX);
      end else begin
         l_eff = context_length_ff;
      end
   end

   assign req_chan.ready = !req_chan.final_req || rpt_free;

   assign ctl.step  = req_chan.valid && req_chan.ready;
   assign ctl.hit   = hit;
   assign ctl.clear = req_chan.final_req;

   mcc_window #(
      .CONTEXT_MAX (CONTEXT_MAX),
      .PATTERN_MAX (PATTERN_MAX)
   ) u_window (
      .clock         (clock),
      .reset         (reset),
      .step          (ctl.step),
      .clear         (ctl.clear),
      .symbol        (req_chan.symbol),
      .pattern_bytes (pattern_bytes_ff),
      .p_eff         (p_eff),
      .l_eff         (l_eff),
      .win_next      (win_next),
      .hit           (hit)
   );

   for (genvar k = 0; k < SLOT_DEPTH; k++) begin : g_slot
      mcc_slot_cell #(
         .SLOT        (k),
         .CONTEXT_MAX (CONTEXT_MAX),
         .PATTERN_MAX (PATTERN_MAX)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .p_eff    (p_eff),
         .l_eff    (l_eff),
         .win_next (win_next),
         .merged   (slot_merged[k])
      );
   end

   mcc_report #(
      .CONTEXT_MAX (CONTEXT_MAX)
   ) u_report (
      .clock    (clock),
      .reset    (reset),
      .load     (ctl.step && ctl.clear),
      .slots    (slot_merged),
      .l_eff    (l_eff),
      .free     (rpt_free),
      .rsp_chan (rsp_chan)
   );

endmodule

/* rtl/mcc_window.sv */
module mcc_window import mcc_pkg::*; #(
   parameter int CONTEXT_MAX = CONTEXT_MAX_DEF,
   parameter int PATTERN_MAX = PATTERN_MAX_DEF,
   localparam int WIN_DEPTH  = 2 * CONTEXT_MAX + PATTERN_MAX
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic                                clear,
   input  logic [SYMBOL_W-1:0]                 symbol,
   input  logic [PBYTES_W-1:0]                 pattern_bytes,
   input  logic [PLEN_W-1:0]                   p_eff,
   input  logic [CLEN_W-1:0]                   l_eff,
   output logic [WIN_DEPTH-1:0][SYMBOL_W-1:0]  win_next,
   output logic                                hit
);

   localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
   localparam int WIN_IDX_W = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

   logic [WIN_DEPTH-1:0][SYMBOL_W-1:0] win_ff;
   logic [FILL_W-1:0]                  fill_ff;
   logic [FILL_W-1:0]                  fill_in;
   logic [FILL_W-1:0]                  fill_sat;
   logic                               match;

   // The newest byte enters at the top and every byte moves one place down.
   always_comb begin
      for (int j = 0; j < WIN_DEPTH - 1; j++) begin
         win_next[j] = win_ff[j + 1];
      end
      win_next[WIN_DEPTH - 1] = symbol;
   end

   always_comb begin
      logic [WIN_IDX_W-1:0] idx;
      fill_sat = (int'(fill_ff) < WIN_DEPTH) ? fill_ff + FILL_W'(1) : fill_ff;
      fill_in  = clear ? '0 : fill_sat;
      match    = (int'(fill_sat) >= 2 * int'(l_eff) + int'(p_eff));
      for (int i = 0; i < PATTERN_MAX; i++) begin
         idx = WIN_IDX_W'(WIN_DEPTH - int'(l_eff) - int'(p_eff) + i);
         if (i < int'(p_eff)) begin
            if (win_next[idx] != pattern_bytes[SYMBOL_W*i +: SYMBOL_W]) begin
               match = 1'b0;
            end
         end
      end
      hit = step && match;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (step) begin
         fill_ff <= fill_in;
      end
   end

   // Bytes below the fill level are never compared, so the window needs no reset.
   always_ff @(posedge clock) begin
      if (step) begin
         win_ff <= win_next;
      end
   end

endmodule

/* rtl/mcc_slot_cell.sv */
module mcc_slot_cell import mcc_pkg::*; #(
   parameter int SLOT        = 0,
   parameter int CONTEXT_MAX = CONTEXT_MAX_DEF,
   parameter int PATTERN_MAX = PATTERN_MAX_DEF,
   localparam int WIN_DEPTH  = 2 * CONTEXT_MAX + PATTERN_MAX
) (
   input  logic                                clock,
   input  logic                                reset,
   input  strm_ctl_type                        ctl,
   input  logic [PLEN_W-1:0]                   p_eff,
   input  logic [CLEN_W-1:0]                   l_eff,
   input  logic [WIN_DEPTH-1:0][SYMBOL_W-1:0]  win_next,
   output slot_type                            merged
);

   localparam int WIN_IDX_W = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

   slot_status_type     status_ff;
   logic [SYMBOL_W-1:0] symbol_ff;

   always_comb begin
      logic [WIN_IDX_W-1:0] tap;
      logic [SYMBOL_W-1:0]  seen;
      merged.status = status_ff;
      merged.symbol = symbol_ff;
      tap           = '0;
      seen          = '0;
      if (ctl.hit && (SLOT < 2 * int'(l_eff))) begin
         // Left slots sit before the pattern, right slots after it.
         if (SLOT < int'(l_eff)) begin
            tap = WIN_IDX_W'(WIN_DEPTH - 2 * int'(l_eff) - int'(p_eff) + SLOT);
         end else begin
            tap = WIN_IDX_W'(WIN_DEPTH - 2 * int'(l_eff) + SLOT);
         end
         seen = win_next[tap];
         case (status_ff)
            ST_NONE: begin
               merged.status = ST_AGREE;
               merged.symbol = seen;
            end
            ST_AGREE: begin
               if (symbol_ff != seen) begin
                  merged.status = ST_CONFLICT;
               end
            end
            default: begin
               merged.status = status_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= ST_NONE;
      end else if (ctl.step) begin
         status_ff <= ctl.clear ? ST_NONE : merged.status;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.step) begin
         symbol_ff <= merged.symbol;
      end
   end

endmodule

/* rtl/mcc_report.sv */
`include "assert_macros.svh"

module mcc_report import mcc_pkg::*; #(
   parameter int CONTEXT_MAX = CONTEXT_MAX_DEF,
   localparam int SLOT_DEPTH = 2 * CONTEXT_MAX
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  slot_type [SLOT_DEPTH-1:0]  slots,
   input  logic [CLEN_W-1:0]          l_eff,
   output logic                       free,
   mcc_rsp_if.source                  rsp_chan
);

   localparam int CNT_W = $clog2(SLOT_DEPTH + 1);

   slot_type [SLOT_DEPTH-1:0] rep_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [POS_W-1:0]          pos_ff;
   logic                      shift;

   assign shift = rsp_chan.valid && rsp_chan.ready;
   // A new report may load while the last beat of the previous one leaves.
   assign free  = (count_ff == '0) || ((count_ff == CNT_W'(1)) && rsp_chan.ready);

   assign rsp_chan.valid            = (count_ff != '0);
   assign rsp_chan.position         = pos_ff;
   assign rsp_chan.consensus_symbol = rep_ff[0].symbol;
   assign rsp_chan.status           = STATUS_W'(rep_ff[0].status);
   assign rsp_chan.is_last          = (count_ff == CNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pos_ff   <= '0;
      end else if (load) begin
         count_ff <= CNT_W'(2 * int'(l_eff));
         pos_ff   <= '0;
      end else if (shift) begin
         count_ff <= count_ff - CNT_W'(1);
         pos_ff   <= pos_ff + POS_W'(1);
      end
   end

   // The report cells pass their beat toward the head one place per taken beat.
   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < SLOT_DEPTH; i++) begin
            rep_ff[i].status <= slots[i].status;
            rep_ff[i].symbol <= (slots[i].status == ST_AGREE) ? slots[i].symbol : '0;
         end
      end else if (shift) begin
         for (int i = 0; i < SLOT_DEPTH - 1; i++) begin
            rep_ff[i] <= rep_ff[i + 1];
         end
      end
   end

   `MCC_ASSERT(a_load_only_when_free, clock, reset, load |-> (count_ff == '0) || ((count_ff == CNT_W'(1)) && rsp_chan.ready))
   `MCC_ASSERT(a_load_starts_report, clock, reset, load |=> (count_ff != '0) && (pos_ff == '0))
   `MCC_ASSERT(a_drain_advances, clock, reset, (shift && !load) |=> (count_ff == $past(count_ff) - CNT_W'(1)) && (pos_ff == $past(pos_ff) + POS_W'(1)))
   `MCC_ASSERT(a_idle_holds, clock, reset, (!shift && !load) |=> $stable(count_ff) && $stable(pos_ff))

endmodule
